FILE: rtl/core/tpd_pkg.sv
// shared types and constants of the touchpad packet decoder
`default_nettype none

package tpd_pkg;

  localparam int PACKET_BYTES = 6;
  localparam int STORE_DEPTH  = PACKET_BYTES - 1;
  localparam int STORE_IW     = $clog2(STORE_DEPTH);
  localparam int CNT_W        = $clog2(PACKET_BYTES);
  localparam int POS_W        = 18;
  localparam int COORD_W      = 16;
  localparam int CFG_IDX_W    = 1;

  localparam logic [COORD_W-1:0] MAX_RESET = 16'd4095;

  localparam logic [3:0] KIND_BITMAP = 4'h3;
  localparam logic [3:0] KIND_ABS    = 4'h6;
  localparam logic [3:0] KIND_REL    = 4'h9;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_X = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_Y = 1'd1;

  localparam logic [POS_W-1:0] POS_HI = 18'h1FFFF;
  localparam logic [POS_W-1:0] POS_LO = 18'h20000;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_DELTA,
    S_CLAMP_X,
    S_CLAMP_Y,
    S_INVERT_Y,
    S_SEND
  } state_t;

  typedef enum logic [1:0] {
    OP_SATADD,
    OP_CLAMP,
    OP_SUB
  } alu_op_t;

  typedef struct packed {
    logic       action;
    logic [7:0] data_byte;
  } in_beat_t;

  typedef struct packed {
    logic [2:0]         finger_index;
    logic               finger_touching;
    logic [COORD_W-1:0] x_pos;
    logic [COORD_W-1:0] y_pos;
    logic               button_pressed;
    logic [2:0]         touch_total;
    logic               last_of_packet;
  } out_beat_t;

endpackage

`default_nettype wire

FILE: rtl/core/tpd_stream_if.sv
// valid/ready stream channel carrying one payload beat
`default_nettype none

interface tpd_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/touchpad_packet_decoder_core.sv
// touchpad packet decoder: byte collector, finger state and report sequencer
//
// Bytes are taken one per cycle while a packet is being collected; bytes before a
// valid start byte (low nibble 3, 6 or 9) are dropped. After the sixth byte the
// block is busy and takes no bytes: a decode step, then for a relative packet one
// saturating add per delta through the shared arithmetic unit (x and y of the finger
// in byte 0, then of the finger in byte 3), then per finger slot the steps clamp x,
// clamp y, invert y and load the output register, which waits while the result side
// holds ready low. Report beats are FINGERS per packet, slot 0 first.
`default_nettype none

module touchpad_packet_decoder_core #(
  parameter int FINGERS = 5
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  tpd_stream_if.sink                         in_ch,
  tpd_stream_if.source                       out_ch,
  input  wire logic                          cfg_we,
  input  wire logic [tpd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [tpd_pkg::COORD_W-1:0]   cfg_data
);

  localparam int IW = (FINGERS > 1) ? $clog2(FINGERS) : 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(FINGERS - 1);
  localparam logic [3:0] FINGERS_N = 4'(FINGERS);

  tpd_pkg::state_t  state_r, state_nxt;
  tpd_pkg::alu_op_t alu_op;

  logic [tpd_pkg::CNT_W-1:0]   byte_cnt_r, byte_cnt_nxt;
  logic [7:0]                  store_r [tpd_pkg::STORE_DEPTH];
  logic [7:0]                  last_byte_r;
  logic                        store_we;
  logic                        last_we;
  logic                        button_r, button_nxt;
  logic [FINGERS-1:0]          active_r, active_nxt;
  logic [FINGERS-1:0]          valid_r, valid_nxt;
  logic [tpd_pkg::POS_W-1:0]   pos_x_r [FINGERS];
  logic [tpd_pkg::POS_W-1:0]   pos_x_nxt [FINGERS];
  logic [tpd_pkg::POS_W-1:0]   pos_y_r [FINGERS];
  logic [tpd_pkg::POS_W-1:0]   pos_y_nxt [FINGERS];
  logic [tpd_pkg::COORD_W-1:0] shown_x_r [FINGERS];
  logic [tpd_pkg::COORD_W-1:0] shown_x_nxt [FINGERS];
  logic [tpd_pkg::COORD_W-1:0] shown_y_r [FINGERS];
  logic [tpd_pkg::COORD_W-1:0] shown_y_nxt [FINGERS];
  logic [IW-1:0]               idx_r, idx_nxt;
  logic [1:0]                  dsel_r, dsel_nxt;
  logic [tpd_pkg::COORD_W-1:0] tmp_r, tmp_nxt;
  logic [tpd_pkg::COORD_W-1:0] max_x_r, max_y_r;
  logic                        out_valid_r, out_valid_nxt;
  tpd_pkg::out_beat_t          out_beat_r, out_beat_nxt;

  logic                        in_fire;
  logic                        start_ok;
  logic [3:0]                  abs_n;
  logic [3:0]                  abs_nm1;
  logic                        abs_ok;
  logic [2:0]                  rel_f;
  logic [2:0]                  rel_fm1;
  logic                        rel_ok;
  logic [7:0]                  rel_d;
  logic [IW-1:0]               rd_slot;
  logic [tpd_pkg::POS_W-1:0]   alu_a, alu_b, alu_res;
  logic [tpd_pkg::POS_W:0]     alu_sum;
  logic [FINGERS-1:0]          touch;
  logic [2:0]                  contacts;

  assign in_fire      = in_ch.valid && in_ch.ready;
  assign in_ch.ready  = (state_r == tpd_pkg::S_IDLE);
  assign out_ch.valid = out_valid_r;
  assign out_ch.payload = out_beat_r;

  assign start_ok = (in_ch.payload.data_byte[3:0] == tpd_pkg::KIND_BITMAP) ||
                    (in_ch.payload.data_byte[3:0] == tpd_pkg::KIND_ABS) ||
                    (in_ch.payload.data_byte[3:0] == tpd_pkg::KIND_REL);

  assign abs_n   = store_r[1][7:4];
  assign abs_nm1 = abs_n - 4'd1;
  assign abs_ok  = (abs_n != 4'd0) && (abs_n <= FINGERS_N);

  // relative packet: steps 0,1 use finger in byte 0, steps 2,3 finger in byte 3
  assign rel_f   = dsel_r[1] ? store_r[3][6:4] : store_r[0][6:4];
  assign rel_fm1 = rel_f - 3'd1;
  assign rel_ok  = (rel_f != 3'd0) && ({1'b0, rel_f} <= FINGERS_N);

  always_comb begin
    case (dsel_r)
      2'd0:    rel_d = store_r[1];
      2'd1:    rel_d = store_r[2];
      2'd2:    rel_d = store_r[4];
      default: rel_d = last_byte_r;
    endcase
  end

  assign rd_slot = (state_r == tpd_pkg::S_DELTA) ? rel_fm1[IW-1:0] : idx_r;

  // shared arithmetic unit
  assign alu_sum = {alu_a[tpd_pkg::POS_W-1], alu_a} + {alu_b[tpd_pkg::POS_W-1], alu_b};

  always_comb begin
    case (alu_op)
      tpd_pkg::OP_SATADD: begin
        if (alu_sum[tpd_pkg::POS_W] != alu_sum[tpd_pkg::POS_W-1]) begin
          alu_res = alu_sum[tpd_pkg::POS_W] ? tpd_pkg::POS_LO : tpd_pkg::POS_HI;
        end else begin
          alu_res = alu_sum[tpd_pkg::POS_W-1:0];
        end
      end
      tpd_pkg::OP_CLAMP: begin
        if (alu_a[tpd_pkg::POS_W-1]) begin
          alu_res = '0;
        end else if (alu_a[tpd_pkg::POS_W-2:0] > alu_b[tpd_pkg::POS_W-2:0]) begin
          alu_res = alu_b;
        end else begin
          alu_res = alu_a;
        end
      end
      tpd_pkg::OP_SUB: alu_res = alu_b - alu_a;
      default:         alu_res = '0;
    endcase
  end

  assign touch = active_r & valid_r;

  always_comb begin
    contacts = 3'd0;
    for (int i = 0; i < FINGERS; i++) begin
      contacts = contacts + 3'(touch[i]);
    end
  end

  always_comb begin
    state_nxt     = state_r;
    byte_cnt_nxt  = byte_cnt_r;
    store_we      = 1'b0;
    last_we       = 1'b0;
    button_nxt    = button_r;
    active_nxt    = active_r;
    valid_nxt     = valid_r;
    pos_x_nxt     = pos_x_r;
    pos_y_nxt     = pos_y_r;
    shown_x_nxt   = shown_x_r;
    shown_y_nxt   = shown_y_r;
    idx_nxt       = idx_r;
    dsel_nxt      = dsel_r;
    tmp_nxt       = tmp_r;
    out_valid_nxt = out_valid_r;
    out_beat_nxt  = out_beat_r;
    alu_op        = tpd_pkg::OP_CLAMP;
    alu_a         = pos_x_r[rd_slot];
    alu_b         = {2'b00, max_x_r};

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      tpd_pkg::S_IDLE: begin
        if (in_fire) begin
          if (in_ch.payload.action) begin
            byte_cnt_nxt = '0;
          end else if (byte_cnt_r == '0 && !start_ok) begin
            byte_cnt_nxt = '0;
          end else if (byte_cnt_r < tpd_pkg::CNT_W'(tpd_pkg::STORE_DEPTH)) begin
            store_we     = 1'b1;
            byte_cnt_nxt = byte_cnt_r + 1'b1;
          end else begin
            last_we      = 1'b1;
            byte_cnt_nxt = '0;
            state_nxt    = tpd_pkg::S_DECODE;
          end
        end
      end
      tpd_pkg::S_DECODE: begin
        idx_nxt   = '0;
        dsel_nxt  = 2'd0;
        state_nxt = tpd_pkg::S_CLAMP_X;
        case (store_r[0][3:0])
          tpd_pkg::KIND_BITMAP: begin
            button_nxt = store_r[0][4];
            active_nxt = store_r[1][FINGERS-1:0];
            valid_nxt  = valid_r & store_r[1][FINGERS-1:0];
          end
          tpd_pkg::KIND_ABS: begin
            if (abs_ok) begin
              button_nxt = store_r[0][4];
              pos_x_nxt[abs_nm1[IW-1:0]] = {6'b0, store_r[1][3:0], store_r[2]};
              pos_y_nxt[abs_nm1[IW-1:0]] = {2'b0, store_r[3], store_r[4]};
              valid_nxt[abs_nm1[IW-1:0]] = 1'b1;
            end
          end
          tpd_pkg::KIND_REL: begin
            button_nxt = store_r[0][7];
            state_nxt  = tpd_pkg::S_DELTA;
          end
          default: begin
            state_nxt = tpd_pkg::S_CLAMP_X;
          end
        endcase
      end
      tpd_pkg::S_DELTA: begin
        alu_op = tpd_pkg::OP_SATADD;
        alu_a  = dsel_r[0] ? pos_y_r[rd_slot] : pos_x_r[rd_slot];
        alu_b  = {{(tpd_pkg::POS_W-8){rel_d[7]}}, rel_d};
        if (rel_ok) begin
          if (dsel_r[0]) begin
            pos_y_nxt[rd_slot] = alu_res;
          end else begin
            pos_x_nxt[rd_slot] = alu_res;
          end
        end
        dsel_nxt = dsel_r + 2'd1;
        if (dsel_r == 2'd3) begin
          state_nxt = tpd_pkg::S_CLAMP_X;
        end
      end
      tpd_pkg::S_CLAMP_X: begin
        alu_op = tpd_pkg::OP_CLAMP;
        alu_a  = pos_x_r[rd_slot];
        alu_b  = {2'b00, max_x_r};
        if (touch[idx_r]) begin
          shown_x_nxt[idx_r] = alu_res[tpd_pkg::COORD_W-1:0];
        end
        state_nxt = tpd_pkg::S_CLAMP_Y;
      end
      tpd_pkg::S_CLAMP_Y: begin
        alu_op    = tpd_pkg::OP_CLAMP;
        alu_a     = pos_y_r[rd_slot];
        alu_b     = {2'b00, max_y_r};
        tmp_nxt   = alu_res[tpd_pkg::COORD_W-1:0];
        state_nxt = tpd_pkg::S_INVERT_Y;
      end
      tpd_pkg::S_INVERT_Y: begin
        alu_op = tpd_pkg::OP_SUB;
        alu_a  = {2'b00, tmp_r};
        alu_b  = {2'b00, max_y_r};
        if (touch[idx_r]) begin
          shown_y_nxt[idx_r] = alu_res[tpd_pkg::COORD_W-1:0];
        end
        state_nxt = tpd_pkg::S_SEND;
      end
      tpd_pkg::S_SEND: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt                = 1'b1;
          out_beat_nxt.finger_index    = 3'(idx_r);
          out_beat_nxt.finger_touching = touch[idx_r];
          out_beat_nxt.x_pos           = shown_x_r[idx_r];
          out_beat_nxt.y_pos           = shown_y_r[idx_r];
          out_beat_nxt.button_pressed  = button_r;
          out_beat_nxt.touch_total     = contacts;
          out_beat_nxt.last_of_packet  = (idx_r == LAST_IDX);
          if (idx_r == LAST_IDX) begin
            state_nxt = tpd_pkg::S_IDLE;
          end else begin
            idx_nxt   = idx_r + 1'b1;
            state_nxt = tpd_pkg::S_CLAMP_X;
          end
        end
      end
      default: state_nxt = tpd_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tpd_pkg::S_IDLE;
      byte_cnt_r  <= '0;
      button_r    <= 1'b0;
      active_r    <= '0;
      valid_r     <= '0;
      idx_r       <= '0;
      dsel_r      <= 2'd0;
      out_valid_r <= 1'b0;
      max_x_r     <= tpd_pkg::MAX_RESET;
      max_y_r     <= tpd_pkg::MAX_RESET;
      for (int i = 0; i < FINGERS; i++) begin
        pos_x_r[i]   <= '0;
        pos_y_r[i]   <= '0;
        shown_x_r[i] <= '0;
        shown_y_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      byte_cnt_r  <= byte_cnt_nxt;
      button_r    <= button_nxt;
      active_r    <= active_nxt;
      valid_r     <= valid_nxt;
      idx_r       <= idx_nxt;
      dsel_r      <= dsel_nxt;
      out_valid_r <= out_valid_nxt;
      pos_x_r     <= pos_x_nxt;
      pos_y_r     <= pos_y_nxt;
      shown_x_r   <= shown_x_nxt;
      shown_y_r   <= shown_y_nxt;
      if (cfg_we && cfg_index == tpd_pkg::CFG_MAX_X) begin
        max_x_r <= cfg_data;
      end
      if (cfg_we && cfg_index == tpd_pkg::CFG_MAX_Y) begin
        max_y_r <= cfg_data;
      end
    end
  end

  // packet bytes and output beat carry no reset
  always_ff @(posedge clk) begin
    if (store_we) begin
      store_r[byte_cnt_r[tpd_pkg::STORE_IW-1:0]] <= in_ch.payload.data_byte;
    end
    if (last_we) begin
      last_byte_r <= in_ch.payload.data_byte;
    end
    tmp_r      <= tmp_nxt;
    out_beat_r <= out_beat_nxt;
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    byte_cnt_r <= tpd_pkg::CNT_W'(tpd_pkg::STORE_DEPTH))
    else $error("byte count beyond packet length");

  a_decode_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == tpd_pkg::S_DECODE |-> byte_cnt_r == '0)
    else $error("byte count not cleared at decode");

  a_valid_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == tpd_pkg::S_SEND))
    else $error("report beat raised outside send step");

  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tpd_pkg::S_SEND && idx_r == LAST_IDX && (!out_valid_r || out_ch.ready))
    |=> state_r == tpd_pkg::S_IDLE && out_beat_r.last_of_packet)
    else $error("sequencer did not return to idle after final slot");

endmodule

`default_nettype wire
